// ===== design/polyphase_rate_converter_top_macros.svh =====
// Assertion macros for the polyphase rate converter.
// Used by the top level; depends on aclk and aresetn being in scope.
`ifndef POLYPHASE_RATE_CONVERTER_TOP_MACROS_SVH
`define POLYPHASE_RATE_CONVERTER_TOP_MACROS_SVH

// Implication in the same cycle.
`define PRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("polyphase rate converter check failed");

// Implication in the next cycle.
`define PRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("polyphase rate converter check failed");

`endif

// ===== design/prc_pkg.sv =====
// Shared constants and types for the polyphase rate converter.
// No dependencies.
package prc_pkg;
    localparam int MAX_PHASES  = 16;
    localparam int MAX_TAPS    = 64;
    localparam int COEF_DEPTH  = MAX_PHASES * MAX_TAPS;
    localparam int PHASE_W     = $clog2(MAX_PHASES);
    localparam int TAP_W       = $clog2(MAX_TAPS);
    localparam int COEF_AW     = $clog2(COEF_DEPTH);
    localparam int PCOUNT_W    = PHASE_W + 1;
    localparam int TCOUNT_W    = TAP_W + 1;
    localparam int PUSH_W      = 7;
    localparam int DATA_W      = 16;
    localparam int ACC_W       = 40;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_COEF   = 2'd1;
    localparam logic [1:0] KIND_PUSH   = 2'd2;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_PUSH   = 2'd2;

    typedef struct packed {
        logic [1:0]          op;
        logic [DATA_W-1:0]   data;
        logic [COEF_AW-1:0]  index;
        logic [PUSH_W-1:0]   push;
    } item_t;
endpackage

// ===== design/polyphase_rate_converter_top.sv =====
// Top level of the polyphase rate converter: configuration registers and the two halves.
// Depends on prc_pkg, prc_front, prc_back and the assertion macro header.
//
//  Channel   Direction  Handshake              Carries
//  s_        in         s_valid / s_ready      kind, sample, table index, coefficient, push
//  m_        out        m_valid / m_ready      output sample, last-of-run flag
//  cfg_      in         cfg_valid / cfg_ready  register index, write data
//
// A table write is taken straight from the queue by the back end. An audio sample passes
// through bookkeeping first; then, for each output it causes, the single shared
// multiply-accumulate unit reads one coefficient and one delayed sample per cycle.
// Reset is synchronous and active low; it clears the delay line through per-entry valid bits.
// A two-entry queue separates the front from the back, so a stalled output only stops input
// once the queue is full.
`include "polyphase_rate_converter_top_macros.svh"

module polyphase_rate_converter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [15:0] s_sample_in,
    input  logic [9:0]  s_table_index,
    input  logic [15:0] s_coef_value,
    input  logic [6:0]  s_push_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_sample_out,
    output logic        m_last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    import prc_pkg::*;

    localparam logic REG_PHASE_COUNT = 1'b0;
    localparam logic REG_TAP_COUNT   = 1'b1;

    logic [4:0]          phase_count_reg;
    logic [6:0]          tap_count_reg;
    logic [PCOUNT_W-1:0] phases;
    logic [TCOUNT_W-1:0] taps;
    logic                q_valid;
    logic                q_pop;
    item_t               q_item;

    // Configuration is always taken; user must keep the block idle whenever written, unchecked.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_count_reg <= 5'd1;
            tap_count_reg   <= 7'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PHASE_COUNT: phase_count_reg <= cfg_data[4:0];
                REG_TAP_COUNT:   tap_count_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp the registers to the supported range: zero acts as one, large values as the maximum.
    always_comb begin
        if (phase_count_reg == 5'd0) begin
            phases = PCOUNT_W'(1);
        end else if (phase_count_reg > 5'(MAX_PHASES)) begin
            phases = PCOUNT_W'(MAX_PHASES);
        end else begin
            phases = PCOUNT_W'(phase_count_reg);
        end
        if (tap_count_reg == 7'd0) begin
            taps = TCOUNT_W'(1);
        end else if (tap_count_reg > 7'(MAX_TAPS)) begin
            taps = TCOUNT_W'(MAX_TAPS);
        end else begin
            taps = TCOUNT_W'(tap_count_reg);
        end
    end

    prc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_sample_in   (s_sample_in),
        .s_table_index (s_table_index),
        .s_coef_value  (s_coef_value),
        .s_push_value  (s_push_value),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    prc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .phases        (phases),
        .taps          (taps),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out  (m_sample_out),
        .m_last_of_run (m_last_of_run)
    );

    // The back end only takes an item from the queue when one is there.
    `PRC_ASSERT_NOW(a_pop_needs_item, q_pop, q_valid)
    // The clamped phase count always lies in the supported range.
    `PRC_ASSERT_NOW(a_phase_range, 1'b1, (phases != '0) && (phases <= PCOUNT_W'(MAX_PHASES)))
    // A popped item leaves the queue with room for the next transfer.
    `PRC_ASSERT_NEXT(a_room_after_pop, q_pop && !s_valid, s_ready)
endmodule

// ===== design/prc_front.sv =====
// Front end: accepts input transfers, classifies them and queues them, but
// drops unknown kinds and push items for a phase index of MAX_PHASES or above. Depends on prc_pkg.
module prc_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_kind,
    input  logic [15:0]              s_sample_in,
    input  logic [9:0]               s_table_index,
    input  logic [15:0]              s_coef_value,
    input  logic [6:0]               s_push_value,
    output logic                     q_valid,
    output prc_pkg::item_t           q_item,
    input  logic                     q_pop
);
    import prc_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    logic       push_en;
    item_t      new_item;

    always_comb begin
        new_item.data  = (s_kind == KIND_COEF) ? s_coef_value : s_sample_in;
        new_item.index = s_table_index;
        new_item.push  = s_push_value;
        new_item.op    = OP_SAMPLE;
        keep           = 1'b0;
        case (s_kind)
            KIND_SAMPLE: begin
                new_item.op = OP_SAMPLE;
                keep        = 1'b1;
            end
            KIND_COEF: begin
                new_item.op = OP_COEF;
                keep        = 1'b1;
            end
            KIND_PUSH: begin
                new_item.op = OP_PUSH;
                keep        = (s_table_index < 10'(MAX_PHASES));
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push_en = s_valid && s_ready && keep;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push_en;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push_en} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ===== design/prc_back.sv =====
// Back end: table writes, delay line, shared multiply-accumulate and output register.
// Depends on prc_pkg.
module prc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [prc_pkg::PCOUNT_W-1:0]  phases,
    input  logic [prc_pkg::TCOUNT_W-1:0]  taps,
    input  logic                          q_valid,
    input  prc_pkg::item_t                q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [15:0]                   m_sample_out,
    output logic                          m_last_of_run
);
    import prc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [TAP_W-1:0]      wp_reg, wp_next;
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [PUSH_W-1:0]     cnt_reg, cnt_next;
    logic [PCOUNT_W-1:0]   nout_reg, nout_next;
    logic [COEF_AW-1:0]    base_reg, base_next;
    logic [TCOUNT_W-1:0]   k_reg, k_next;
    logic                  p1_reg, p2_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [31:0]    prod_reg;
    logic [DATA_W-1:0]     res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    logic [DATA_W-1:0]     coef_mem [COEF_DEPTH];
    logic [DATA_W-1:0]     dly_mem  [MAX_TAPS];
    logic [MAX_TAPS-1:0]   dvalid_reg;
    logic [PUSH_W-1:0]     push_tbl_reg [MAX_PHASES];
    logic signed [DATA_W-1:0] coef_rd_reg, dly_rd_reg;
    logic                  dv_rd_reg;

    logic                  issue;
    logic [COEF_AW-1:0]    coef_addr;
    logic [TAP_W-1:0]      dly_addr;
    logic [PUSH_W-1:0]     need;
    logic                  more;
    logic                  out_free;
    logic                  start;
    logic                  coef_we, push_we, dly_we;
    logic [10:0]           base_full;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-16:0] shifted;

    assign need      = push_tbl_reg[phase_reg];
    assign more      = (nout_reg < phases) && (cnt_reg >= need);
    assign out_free  = !out_valid_reg || m_ready;
    assign issue     = (state_reg == ST_MAC) && (k_reg < taps);
    assign coef_addr = base_reg + COEF_AW'(k_reg[TAP_W-1:0]);
    assign dly_addr  = wp_reg - taps[TAP_W-1:0] + k_reg[TAP_W-1:0];
    assign base_full = 11'(phase_reg * taps);
    assign rounded   = acc_reg + ACC_W'(16384);
    assign shifted   = rounded[ACC_W-1:15];

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign coef_we = q_pop && (q_item.op == OP_COEF);
    assign push_we = q_pop && (q_item.op == OP_PUSH);
    assign dly_we  = q_pop && (q_item.op == OP_SAMPLE);

    assign m_valid       = out_valid_reg;
    assign m_sample_out  = out_data_reg;
    assign m_last_of_run = out_last_reg;

    always_comb begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        nout_next      = nout_reg;
        base_next      = base_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        start          = 1'b0;

        if (p2_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end

        case (state_reg)
            ST_IDLE: begin
                if (dly_we) begin
                    wp_next   = wp_reg + 1'b1;
                    cnt_next  = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
                    nout_next = '0;
                    if ({1'b0, phase_reg} >= phases) begin
                        phase_next = '0;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (more) begin
                    start = 1'b1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAC: begin
                if (issue) begin
                    k_next = k_reg + 1'b1;
                end else if (!p1_reg && !p2_reg) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (shifted > 25'sd32767) begin
                    res_next = 16'h7FFF;
                end else if (shifted < -25'sd32768) begin
                    res_next = 16'h8000;
                end else begin
                    res_next = shifted[DATA_W-1:0];
                end
                nout_next  = nout_reg + 1'b1;
                phase_next = ({1'b0, phase_reg} + 1'b1 >= phases) ? '0 : phase_reg + 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    out_last_next  = !more;
                    if (more) begin
                        start = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (start) begin
            cnt_next   = cnt_reg - need;
            base_next  = base_full[COEF_AW-1:0];
            k_next     = '0;
            acc_next   = '0;
            state_next = ST_MAC;
        end
    end

    // Table and delay line storage with registered reads, plus the product and other datapath registers without reset.
    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[q_item.index] <= q_item.data;
        end
        if (dly_we) begin
            dly_mem[wp_reg] <= q_item.data;
        end
        if (push_we) begin
            push_tbl_reg[q_item.index[PHASE_W-1:0]] <= q_item.push;
        end
        coef_rd_reg <= coef_mem[coef_addr];
        dly_rd_reg  <= dly_mem[dly_addr];
        dv_rd_reg   <= dvalid_reg[dly_addr];
        prod_reg    <= (dv_rd_reg ? dly_rd_reg : 16'sd0) * coef_rd_reg;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        res_reg     <= res_next;
        base_reg    <= base_next;
        acc_reg     <= acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            nout_reg      <= '0;
            k_reg         <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            dvalid_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            nout_reg      <= nout_next;
            k_reg         <= k_next;
            p1_reg        <= issue;
            p2_reg        <= p1_reg;
            out_valid_reg <= out_valid_next;
            if (dly_we) begin
                dvalid_reg[wp_reg] <= 1'b1;
            end
        end
    end
endmodule
